### src/cdcr_pkg.sv
// Shared types, codes and helper functions for the CD changer bus responder.
// No dependencies; every other file in src imports this package.
package cdcr_pkg;

  // Field widths fixed by the bus format.
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned TrackW   = 7;
  localparam int unsigned PayloadW = 64;
  localparam int unsigned LenW     = 4;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 2;

  // Default depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register reset values.
  localparam logic [ByteW-1:0] BROADCAST_RESET = 8'd255;
  localparam logic [ByteW-1:0] RADIO_RESET     = 8'd104;
  localparam logic [TimeW-1:0] PERIOD_RESET    = 32'd5000;

  // Received frame codes.
  localparam logic [ByteW-1:0] LEN_PING      = 8'h03;
  localparam logic [ByteW-1:0] LEN_CONTROL   = 8'h05;
  localparam logic [ByteW-1:0] CMD_PING      = 8'h01;
  localparam logic [ByteW-1:0] CMD_CONTROL   = 8'h38;
  localparam logic [ByteW-1:0] SUB_STATUS    = 8'h00;
  localparam logic [ByteW-1:0] SUB_STOP      = 8'h01;
  localparam logic [ByteW-1:0] SUB_PLAY      = 8'h03;
  localparam logic [ByteW-1:0] SUB_SCAN      = 8'h04;
  localparam logic [ByteW-1:0] SUB_DISC      = 8'h06;
  localparam logic [ByteW-1:0] SUB_TRACK_A   = 8'h0A;
  localparam logic [ByteW-1:0] SUB_TRACK_B   = 8'h05;
  localparam logic [ByteW-1:0] ARG_FORWARD   = 8'h00;
  localparam logic [ByteW-1:0] ARG_BACKWARD  = 8'h01;

  // Track limits and outgoing frame constants.
  localparam logic [TrackW-1:0]   TRACK_FIRST      = 7'd1;
  localparam logic [TrackW-1:0]   TRACK_LAST       = 7'd99;
  localparam logic [ByteW-1:0]    DISC_RESET       = 8'd1;
  localparam logic [ByteW-1:0]    STATUS_HEADER    = 8'h39;
  localparam logic [ByteW-1:0]    STATUS_FIXED     = 8'h3F;
  localparam logic [PayloadW-1:0] ANNOUNCE_PAYLOAD = 64'h0102;
  localparam logic [PayloadW-1:0] PING_PAYLOAD     = 64'h0002;
  localparam logic [LenW-1:0]     SHORT_LEN        = 4'd2;
  localparam logic [LenW-1:0]     STATUS_LEN       = 4'd8;

  // Request kinds on the input channel.
  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_POLL  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BROADCAST = 2'd0,
    CFG_RADIO     = 2'd1,
    CFG_PERIOD    = 2'd2
  } cfg_index_t;

  // Play modes.
  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_PLAY = 2'd1,
    MODE_FF   = 2'd2,
    MODE_FB   = 2'd3
  } play_mode_t;

  // Kinds of outgoing frames.
  typedef enum logic [1:0] {
    KIND_ANNOUNCE = 2'd1,
    KIND_PING     = 2'd2,
    KIND_STATUS   = 2'd3
  } send_kind_t;

  // Classified operations handed from the front to the back.
  typedef enum logic [3:0] {
    OP_IGNORE = 4'd0,
    OP_PING   = 4'd1,
    OP_STATUS = 4'd2,
    OP_STOP   = 4'd3,
    OP_PLAY   = 4'd4,
    OP_FF     = 4'd5,
    OP_FB     = 4'd6,
    OP_DISC   = 4'd7,
    OP_NEXT   = 4'd8,
    OP_PREV   = 4'd9,
    OP_POLL   = 4'd10
  } op_t;

  // One queued operation.
  typedef struct packed {
    op_t              op;
    logic [ByteW-1:0] arg;
    logic [TimeW-1:0] now_time;
    logic             tx_accept;
  } item_t;

  // One outgoing frame offer.
  typedef struct packed {
    send_kind_t          kind;
    logic [ByteW-1:0]    dest;
    logic [LenW-1:0]     len;
    logic [PayloadW-1:0] bytes;
  } result_t;

  // Track number (1..99) to two BCD digits; tens by reciprocal 205/2048.
  function automatic logic [ByteW-1:0] track_bcd(input logic [TrackW-1:0] track);
    logic [17:0] prod;
    logic [3:0]  tens;
    logic [7:0]  ones;
    prod = 18'(track) * 18'd205;
    tens = prod[14:11];
    ones = 8'(track) - 8'(tens) * 8'd10;
    return {tens, ones[3:0]};
  endfunction

  // Eight-byte status frame payload.
  function automatic logic [PayloadW-1:0] status_payload(input play_mode_t mode,
                                                         input logic [ByteW-1:0] disc,
                                                         input logic [TrackW-1:0] track);
    logic [ByteW-1:0] m1;
    logic [ByteW-1:0] m2;
    case (mode)
      MODE_STOP: begin m1 = 8'h00; m2 = 8'h02; end
      MODE_PLAY: begin m1 = 8'h00; m2 = 8'h09; end
      MODE_FF:   begin m1 = 8'h03; m2 = 8'h09; end
      default:   begin m1 = 8'h04; m2 = 8'h09; end
    endcase
    return {track_bcd(track), disc, 8'h00, STATUS_FIXED, 8'h00, m2, m1, STATUS_HEADER};
  endfunction

endpackage

### src/cdcr_front.sv
// Front part: accepts input transactions and classifies them into operations.
// Depends on cdcr_pkg; feeds cdcr_queue.
module cdcr_front (
  input  logic                         req_type,
  input  logic [cdcr_pkg::ByteW-1:0]   frame_length,
  input  logic [cdcr_pkg::ByteW-1:0]   frame_command,
  input  logic [cdcr_pkg::ByteW-1:0]   frame_subcommand,
  input  logic [cdcr_pkg::ByteW-1:0]   frame_argument,
  input  logic [cdcr_pkg::TimeW-1:0]   now_time,
  input  logic                         tx_accept,
  input  logic                         accept,
  output logic                         push,
  output cdcr_pkg::item_t              item
);
  import cdcr_pkg::*;

  op_t op;
  logic is_ctrl;

  // Decode a frame or poll into one operation code.
  always_comb begin
    op = OP_IGNORE;
    is_ctrl = (frame_length == LEN_CONTROL) && (frame_command == CMD_CONTROL);
    if (req_type == REQ_POLL) begin
      op = OP_POLL;
    end else if (frame_length == LEN_PING && frame_command == CMD_PING) begin
      op = OP_PING;
    end else if (is_ctrl) begin
      if (frame_subcommand == SUB_STATUS && frame_argument == ARG_FORWARD) begin
        op = OP_STATUS;
      end else if (frame_subcommand == SUB_STOP && frame_argument == ARG_FORWARD) begin
        op = OP_STOP;
      end else if (frame_subcommand == SUB_PLAY && frame_argument == ARG_FORWARD) begin
        op = OP_PLAY;
      end else if (frame_subcommand == SUB_SCAN && frame_argument == ARG_FORWARD) begin
        op = OP_FF;
      end else if (frame_subcommand == SUB_SCAN && frame_argument == ARG_BACKWARD) begin
        op = OP_FB;
      end else if (frame_subcommand == SUB_DISC) begin
        op = OP_DISC;
      end else if ((frame_subcommand == SUB_TRACK_A || frame_subcommand == SUB_TRACK_B)
                   && frame_argument == ARG_FORWARD) begin
        op = OP_NEXT;
      end else if ((frame_subcommand == SUB_TRACK_A || frame_subcommand == SUB_TRACK_B)
                   && frame_argument == ARG_BACKWARD) begin
        op = OP_PREV;
      end
    end
  end

  // Frames with no effect are dropped here and never occupy the queue.
  assign push           = accept && (op != OP_IGNORE);
  assign item.op        = op;
  assign item.arg       = frame_argument;
  assign item.now_time  = now_time;
  assign item.tx_accept = tx_accept;

endmodule

### src/cdcr_queue.sv
// Short FIFO of classified operations between the front and back parts.
// Depends on cdcr_pkg for the entry type.
module cdcr_queue #(
  parameter int unsigned Depth = cdcr_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cdcr_pkg::item_t     push_item,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output cdcr_pkg::item_t     head_item
);
  import cdcr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == FullCnt);
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

### src/cdcr_back.sv
// Back part: changer state, configuration registers, poll arbitration and
// the output register. Depends on cdcr_pkg; fed by cdcr_queue.
module cdcr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [cdcr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cdcr_pkg::CfgDataW-1:0] cfg_data,
  input  cdcr_pkg::item_t               head_item,
  input  logic                          head_valid,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cdcr_pkg::result_t             out_result
);
  import cdcr_pkg::*;

  // Configuration registers.
  logic [ByteW-1:0] broadcast_address;
  logic [ByteW-1:0] radio_address;
  logic [TimeW-1:0] announce_period;

  // Changer state.
  logic              announce_pending, announce_pending_next;
  logic              ping_pending,     ping_pending_next;
  logic              status_pending,   status_pending_next;
  play_mode_t        play_mode,        play_mode_next;
  logic [ByteW-1:0]  disc_number,      disc_number_next;
  logic [TrackW-1:0] track_number,     track_number_next;
  logic [TimeW-1:0]  announce_deadline, announce_deadline_next;

  logic    out_free;
  logic    is_poll;
  logic    ann_fire;
  logic    has_result;
  result_t result_next;

  // A poll needs the output register; frames only touch state.
  assign out_free = !out_valid || !out_stall;
  assign is_poll  = (head_item.op == OP_POLL);
  assign pop      = head_valid && (!is_poll || out_free);
  assign ann_fire = announce_pending && (announce_deadline < head_item.now_time);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      broadcast_address <= BROADCAST_RESET;
      radio_address     <= RADIO_RESET;
      announce_period   <= PERIOD_RESET;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_BROADCAST: broadcast_address <= cfg_data[ByteW-1:0];
        CFG_RADIO:     radio_address     <= cfg_data[ByteW-1:0];
        CFG_PERIOD:    announce_period   <= cfg_data[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // Next state and frame offer for the operation at the queue head.
  always_comb begin
    announce_pending_next  = announce_pending;
    ping_pending_next      = ping_pending;
    status_pending_next    = status_pending;
    play_mode_next         = play_mode;
    disc_number_next       = disc_number;
    track_number_next      = track_number;
    announce_deadline_next = announce_deadline;
    has_result             = 1'b0;
    result_next.kind       = KIND_STATUS;
    result_next.dest       = radio_address;
    result_next.len        = STATUS_LEN;
    result_next.bytes      = status_payload(play_mode, disc_number, track_number);
    if (pop) begin
      case (head_item.op)
        OP_PING: begin
          ping_pending_next     = 1'b1;
          announce_pending_next = 1'b0;
        end
        OP_STATUS: status_pending_next = 1'b1;
        OP_STOP: begin
          play_mode_next      = MODE_STOP;
          status_pending_next = 1'b1;
        end
        OP_PLAY: begin
          play_mode_next      = MODE_PLAY;
          status_pending_next = 1'b1;
        end
        OP_FF: begin
          play_mode_next      = MODE_FF;
          status_pending_next = 1'b1;
        end
        OP_FB: begin
          play_mode_next      = MODE_FB;
          status_pending_next = 1'b1;
        end
        OP_DISC: begin
          track_number_next   = TRACK_FIRST;
          disc_number_next    = head_item.arg;
          play_mode_next      = MODE_PLAY;
          status_pending_next = 1'b1;
        end
        OP_NEXT: begin
          if (track_number < TRACK_LAST) begin
            track_number_next = track_number + 1'b1;
          end
          status_pending_next = 1'b1;
        end
        OP_PREV: begin
          if (track_number > TRACK_FIRST) begin
            track_number_next = track_number - 1'b1;
          end
          status_pending_next = 1'b1;
        end
        OP_POLL: begin
          if (ann_fire) begin
            has_result             = 1'b1;
            result_next.kind       = KIND_ANNOUNCE;
            result_next.dest       = broadcast_address;
            result_next.len        = SHORT_LEN;
            result_next.bytes      = ANNOUNCE_PAYLOAD;
            announce_deadline_next = head_item.now_time + announce_period;
          end else if (ping_pending) begin
            has_result        = 1'b1;
            result_next.kind  = KIND_PING;
            result_next.dest  = broadcast_address;
            result_next.len   = SHORT_LEN;
            result_next.bytes = PING_PAYLOAD;
            if (head_item.tx_accept) begin
              ping_pending_next = 1'b0;
            end
          end else if (status_pending) begin
            has_result = 1'b1;
            if (head_item.tx_accept) begin
              status_pending_next = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      announce_pending  <= 1'b1;
      ping_pending      <= 1'b0;
      status_pending    <= 1'b0;
      play_mode         <= MODE_STOP;
      disc_number       <= DISC_RESET;
      track_number      <= TRACK_FIRST;
      announce_deadline <= '0;
    end else begin
      announce_pending  <= announce_pending_next;
      ping_pending      <= ping_pending_next;
      status_pending    <= status_pending_next;
      play_mode         <= play_mode_next;
      disc_number       <= disc_number_next;
      track_number      <= track_number_next;
      announce_deadline <= announce_deadline_next;
    end
  end

  // Output register: loads a new offer, or empties once its transaction is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && has_result) begin
      out_result <= result_next;
    end
  end

  // Track number never leaves its legal range.
  a_track_range: assert property (@(posedge clk) disable iff (rst)
    track_number >= TRACK_FIRST && track_number <= TRACK_LAST)
    else $error("track number out of range");

  // An offered frame always carries a real kind.
  a_kind_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_result.kind != 2'd0)
    else $error("offered frame has no kind");

  // A ping frame stops announcements.
  a_ping_stops_announce: assert property (@(posedge clk) disable iff (rst)
    pop && head_item.op == OP_PING |=> !announce_pending && ping_pending)
    else $error("ping did not stop announcements");

  // A fired announcement re-arms the deadline from the poll time.
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    pop && is_poll && ann_fire |=>
      announce_deadline == $past(head_item.now_time + announce_period))
    else $error("announcement deadline not re-armed");

  // No poll is taken while the output register is full and stalled.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !(pop && is_poll))
    else $error("poll taken while output blocked");

endmodule

### src/cd_changer_bus_responder.sv
// Top level of the CD changer bus responder: front decoder, operation queue
// and back part. Depends on cdcr_pkg, cdcr_front, cdcr_queue and cdcr_back.
//
//   Channel | Handshake           | Contents
//   --------+---------------------+-----------------------------------------------
//   in      | in_valid / in_stall | req_type, frame bytes, now_time, tx_accept
//   out     | out_valid/out_stall | send_kind, dest_address, payload_length, bytes
//   cfg     | cfg_write           | cfg_index, cfg_data (write only)
//
// One transaction per cycle sustained while in_stall is low; a poll's offer reaches
// the output once the queue entry is registered and then the output register loads.
// The queue holds QueueDepth operations; in_stall rises only when it is full.
// Polls wait at the queue head while the output register is full and stalled;
// operations ahead of them reach the state, those behind them wait. Reset is
// synchronous and gives the power-up state with no clearing pass.
module cd_changer_bus_responder #(
  parameter int unsigned QueueDepth = cdcr_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [cdcr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cdcr_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [cdcr_pkg::ByteW-1:0]    frame_length,
  input  logic [cdcr_pkg::ByteW-1:0]    frame_command,
  input  logic [cdcr_pkg::ByteW-1:0]    frame_subcommand,
  input  logic [cdcr_pkg::ByteW-1:0]    frame_argument,
  input  logic [cdcr_pkg::TimeW-1:0]    now_time,
  input  logic                          tx_accept,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    send_kind,
  output logic [cdcr_pkg::ByteW-1:0]    dest_address,
  output logic [cdcr_pkg::LenW-1:0]     payload_length,
  output logic [cdcr_pkg::PayloadW-1:0] payload_bytes
);
  import cdcr_pkg::*;

  logic    push;
  logic    full;
  item_t   push_item;
  item_t   head_item;
  logic    head_valid;
  logic    pop;
  result_t out_result;

  assign in_stall = full;

  cdcr_front u_front (
    .req_type         (req_type),
    .frame_length     (frame_length),
    .frame_command    (frame_command),
    .frame_subcommand (frame_subcommand),
    .frame_argument   (frame_argument),
    .now_time         (now_time),
    .tx_accept        (tx_accept),
    .accept           (in_valid && !full),
    .push             (push),
    .item             (push_item)
  );

  cdcr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  cdcr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_item  (head_item),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign send_kind      = out_result.kind;
  assign dest_address   = out_result.dest;
  assign payload_length = out_result.len;
  assign payload_bytes  = out_result.bytes;

endmodule
